FILE: rtl/mlch_pkg.sv
// Shared types, codes and default sizes of the multi-layer coverage histogram.
// No dependencies; the top level and the testbench import it.
`default_nettype none
package mlch_pkg;

   localparam int DEF_MAX_LAYERS  = 16;
   localparam int DEF_MAX_BUCKETS = 4096;
   localparam int DEF_MAX_PIXELS  = 4096;

   localparam int RESET_BASE  = 8;
   localparam int RESET_MULT  = 2;
   localparam int RESET_LAYERS = 16;
   localparam int RESET_PIXELS = 1024;

   localparam int CSR_W  = 13;
   localparam int CSR_IW = 2;

   localparam logic [CSR_IW-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MULT   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_LAYERS = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_PIXELS = 2'd3;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_READ    = 2'd1,
      CMD_DENSITY = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type      command;
      logic [3:0]   layer;
      logic [63:0]  value;
      logic [31:0]  amount;
      logic [11:0]  pixel_x;
   } req_type;

   typedef struct packed {
      logic         accepted;
      logic [31:0]  bucket_count;
      logic [12:0]  occupied_count;
      logic [12:0]  column_buckets;
      logic [16:0]  density_q16;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/mlch_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module mlch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/mlch_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing; used by the histogram top level for all divisions.
`default_nettype none
module mlch_div #(
   parameter int DW = 64,
   parameter int VW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic      [DW-1:0] quotient,
   output logic      [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] q_ff;
   logic [VW-1:0] r_ff;
   logic [VW-1:0] d_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          ge;

   assign trial = {r_ff, q_ff[DW-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CW'(1));
         if (start) begin
            q_ff    <= dividend;
            r_ff    <= '0;
            d_ff    <= divisor;
            cnt_ff  <= CW'(DW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            r_ff   <= ge ? diff[VW-1:0] : trial[VW-1:0];
            q_ff   <= {q_ff[DW-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule
`default_nettype wire

FILE: rtl/multi_layer_coverage_histogram.sv
// Multi-layer coverage histogram: top level, command sequencer and bucket memory.
// Depends on mlch_pkg, mlch_ram and mlch_div.
//
// One command is worked on at a time. Add is dominated by the bit-serial modulo of
// the 64-bit value by the layer size. Density is dominated by three serial divisions
// and the one-read-per-cycle bucket scan of the column. Clear, reset and any write
// of the base size, multiplier or layer count register start a clearing pass over
// all MAX_LAYERS*MAX_BUCKETS words (65536 by default), during which no command is
// taken; the layer sizes are rebuilt in the same pass.
// A finished result waits in an output register while the next command is taken.
`default_nettype none
module multi_layer_coverage_histogram
   import mlch_pkg::*;
#(
   parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
   parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
   parameter int MAX_PIXELS  = DEF_MAX_PIXELS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   localparam int DEPTH = MAX_LAYERS * MAX_BUCKETS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(MAX_LAYERS > 1 ? MAX_LAYERS : 2);
   localparam int BW    = $clog2(MAX_BUCKETS);
   localparam int CAP_W = $clog2(MAX_BUCKETS + 1);
   localparam int PIX_W = $clog2(MAX_PIXELS + 1);
   localparam int DVW   = CAP_W > PIX_W ? CAP_W : PIX_W;
   localparam int QW    = CAP_W + 13;
   localparam int DW    = 64;

   typedef enum logic [4:0] {
      S_PROF, S_SWEEP, S_IDLE,
      S_ADD_GO, S_ADD_WAIT, S_ADD_RD, S_ADD_WR,
      S_READ_CHK, S_READ_RD, S_READ_TAKE,
      S_DEN_MUL, S_DEN_S_GO, S_DEN_S_WAIT, S_DEN_E_GO, S_DEN_E_WAIT,
      S_DEN_CLAMP, S_DEN_SCAN, S_DEN_DRAIN, S_FRAC_GO, S_FRAC_WAIT,
      S_FINISH
   } state_type;

   state_type        state_ff;
   logic [CSR_W-1:0] base_ff, mul_ff, pw_ff;
   logic [4:0]       lcnt_ff;
   logic [CAP_W-1:0] sizes_ff [MAX_LAYERS];
   logic [CAP_W-1:0] cap_ff, capl_ff, end_ff, occ_ff, tot_ff;
   logic [AW-1:0]    cnt_ff;
   logic [LW-1:0]    lidx_ff;
   logic [BW-1:0]    boff_ff;
   logic [QW-1:0]    prod_ff, startq_ff, endq_ff;
   req_type          req_ff;
   rsp_type          res_ff, rsp_ff;
   logic             rsp_valid_ff, clr_ff, scan_rd_ff;

   logic [CAP_W-1:0] cap_init, cap_next;
   logic [CAP_W+CSR_W-1:0] cap_prod;
   logic [CSR_W-1:0] base_eff, mul_eff;
   logic [PIX_W-1:0] width_eff;
   logic [31:0]      nlayers;
   logic             layer_ok;
   logic [QW-1:0]    capq, s_q, e_q, e1_q;
   logic             narrow, empty_col;
   rsp_type          res_init;
   logic             prof_wr, fin_go;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr, bucket_addr;
   logic [31:0]      ram_wdata, ram_rdata;

   logic             div_start, div_busy, div_done;
   logic [DW-1:0]    div_dividend, div_quot;
   logic [DVW-1:0]   div_divisor, div_rem;

   assign base_eff  = (base_ff == '0) ? CSR_W'(1) : base_ff;
   assign mul_eff   = (mul_ff == '0) ? CSR_W'(1) : mul_ff;
   assign cap_init  = CAP_W'((32'(base_eff) > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS)
                                                              : 32'(base_eff));
   assign cap_prod  = (CAP_W+CSR_W)'(cap_ff) * (CAP_W+CSR_W)'(mul_eff);
   assign cap_next  = (cap_prod > (CAP_W+CSR_W)'(MAX_BUCKETS)) ? CAP_W'(MAX_BUCKETS)
                                                              : CAP_W'(cap_prod);
   assign width_eff = PIX_W'((32'(pw_ff) > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS)
                                                           : 32'(pw_ff));
   assign nlayers   = (32'(lcnt_ff) > 32'(MAX_LAYERS)) ? 32'(MAX_LAYERS) : 32'(lcnt_ff);
   assign layer_ok  = 32'(req_data.layer) < nlayers;

   assign prof_wr   = csr_we && (csr_index inside {CSR_BASE, CSR_MULT, CSR_LAYERS});
   assign fin_go    = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall) && !prof_wr;

   always_comb begin
      res_init          = '0;
      res_init.accepted = (req_data.command == CMD_CLEAR) || layer_ok;
   end

   assign capq      = QW'(capl_ff);
   assign narrow    = 32'(capl_ff) <= 32'(width_eff);
   assign e1_q      = (endq_ff <= startq_ff) ? startq_ff + 1'b1 : endq_ff;

   always_comb begin
      if (narrow) begin
         s_q = (startq_ff >= capq) ? capq - 1'b1 : startq_ff;
         e_q = s_q + 1'b1;
      end else begin
         s_q = startq_ff;
         e_q = (e1_q > capq) ? capq : e1_q;
      end
   end
   assign empty_col = s_q >= e_q;

   assign bucket_addr = AW'(32'(lidx_ff) * MAX_BUCKETS + 32'(boff_ff));
   assign ram_raddr   = bucket_addr;
   assign ram_re      = (state_ff == S_ADD_RD) || (state_ff == S_READ_RD) ||
                        (state_ff == S_DEN_SCAN);
   assign ram_we      = (state_ff == S_SWEEP) || (state_ff == S_ADD_WR);
   assign ram_waddr   = (state_ff == S_SWEEP) ? cnt_ff : bucket_addr;
   assign ram_wdata   = (state_ff == S_SWEEP) ? 32'd0 : ram_rdata + req_ff.amount;

   assign div_start = (state_ff == S_ADD_GO) || (state_ff == S_DEN_S_GO) ||
                      (state_ff == S_DEN_E_GO) || (state_ff == S_FRAC_GO);

   always_comb begin
      case (state_ff)
         S_ADD_GO: begin
            div_dividend = req_ff.value;
            div_divisor  = DVW'(capl_ff);
         end
         S_DEN_S_GO: begin
            div_dividend = DW'(prod_ff);
            div_divisor  = DVW'(width_eff);
         end
         S_DEN_E_GO: begin
            div_dividend = DW'(prod_ff) + DW'(capl_ff);
            div_divisor  = DVW'(width_eff);
         end
         default: begin
            div_dividend = DW'({occ_ff, 16'd0});
            div_divisor  = DVW'(tot_ff);
         end
      endcase
   end

   mlch_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mlch_div #(.DW(DW), .VW(DVW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PROF;
         base_ff      <= CSR_W'(RESET_BASE);
         mul_ff       <= CSR_W'(RESET_MULT);
         lcnt_ff      <= 5'(RESET_LAYERS);
         pw_ff        <= CSR_W'(RESET_PIXELS);
         rsp_valid_ff <= 1'b0;
         clr_ff       <= 1'b0;
         scan_rd_ff   <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         scan_rd_ff <= (state_ff == S_DEN_SCAN);
         if (scan_rd_ff && ram_rdata != 32'd0) begin
            occ_ff <= occ_ff + 1'b1;
         end
         rsp_valid_ff <= fin_go || (rsp_valid_ff && rsp_stall);
         if (prof_wr) begin
            state_ff <= S_PROF;
         end else begin
            case (state_ff)
               S_PROF: begin
                  cap_ff   <= cap_init;
                  cnt_ff   <= '0;
                  state_ff <= S_SWEEP;
               end
               S_SWEEP: begin
                  if (cnt_ff < AW'(MAX_LAYERS)) begin
                     sizes_ff[LW'(cnt_ff)] <= cap_ff;
                     cap_ff <= cap_next;
                  end
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == AW'(DEPTH - 1)) begin
                     clr_ff   <= 1'b0;
                     state_ff <= clr_ff ? S_FINISH : S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_valid) begin
                     req_ff  <= req_data;
                     res_ff  <= res_init;
                     lidx_ff <= LW'(req_data.layer);
                     capl_ff <= sizes_ff[LW'(req_data.layer)];
                     if (req_data.command == CMD_CLEAR) begin
                        clr_ff   <= 1'b1;
                        state_ff <= S_PROF;
                     end else if (!layer_ok) begin
                        state_ff <= S_FINISH;
                     end else begin
                        case (req_data.command)
                           CMD_ADD:  state_ff <= S_ADD_GO;
                           CMD_READ: state_ff <= S_READ_CHK;
                           default:  state_ff <= (width_eff == '0) ? S_FINISH : S_DEN_MUL;
                        endcase
                     end
                  end
               end
               S_ADD_GO:   state_ff <= S_ADD_WAIT;
               S_ADD_WAIT: begin
                  if (div_done) begin
                     boff_ff  <= BW'(div_rem);
                     state_ff <= S_ADD_RD;
                  end
               end
               S_ADD_RD:   state_ff <= S_ADD_WR;
               S_ADD_WR:   state_ff <= S_FINISH;
               S_READ_CHK: begin
                  if (req_ff.value < 64'(capl_ff)) begin
                     boff_ff  <= BW'(req_ff.value);
                     state_ff <= S_READ_RD;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
               S_READ_RD:  state_ff <= S_READ_TAKE;
               S_READ_TAKE: begin
                  res_ff.bucket_count <= ram_rdata;
                  state_ff <= S_FINISH;
               end
               S_DEN_MUL: begin
                  prod_ff  <= QW'(req_ff.pixel_x) * QW'(capl_ff);
                  state_ff <= S_DEN_S_GO;
               end
               S_DEN_S_GO: state_ff <= S_DEN_S_WAIT;
               S_DEN_S_WAIT: begin
                  if (div_done) begin
                     startq_ff <= div_quot[QW-1:0];
                     state_ff  <= S_DEN_E_GO;
                  end
               end
               S_DEN_E_GO: state_ff <= S_DEN_E_WAIT;
               S_DEN_E_WAIT: begin
                  if (div_done) begin
                     endq_ff  <= div_quot[QW-1:0];
                     state_ff <= S_DEN_CLAMP;
                  end
               end
               S_DEN_CLAMP: begin
                  occ_ff  <= '0;
                  boff_ff <= BW'(s_q);
                  end_ff  <= CAP_W'(e_q);
                  tot_ff  <= CAP_W'(e_q - s_q);
                  state_ff <= empty_col ? S_FINISH : S_DEN_SCAN;
               end
               S_DEN_SCAN: begin
                  boff_ff <= boff_ff + 1'b1;
                  if (CAP_W'(boff_ff) + 1'b1 == end_ff) begin
                     state_ff <= S_DEN_DRAIN;
                  end
               end
               S_DEN_DRAIN: state_ff <= S_FRAC_GO;
               S_FRAC_GO:   state_ff <= S_FRAC_WAIT;
               S_FRAC_WAIT: begin
                  if (div_done) begin
                     res_ff   <= {res_ff.accepted, res_ff.bucket_count, 13'(occ_ff),
                                  13'(tot_ff), 17'(div_quot)};
                     state_ff <= S_FINISH;
                  end
               end
               S_FINISH: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     rsp_ff   <= res_ff;
                     state_ff <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:   base_ff <= csr_wdata;
               CSR_MULT:   mul_ff  <= csr_wdata;
               CSR_LAYERS: lcnt_ff <= csr_wdata[4:0];
               CSR_PIXELS: pw_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider restarted while busy");

   a_count_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bucket_count != 32'd0) |-> rsp_data.accepted)
      else $error("count returned for a command that was not taken");

   a_dens_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.density_q16 <= 17'h10000))
      else $error("density above one");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we) else $error("memory written while idle");

endmodule
`default_nettype wire

FILE: verif/multi_layer_coverage_histogram_tb.sv
// Self-checking testbench for multi_layer_coverage_histogram; depends on mlch_pkg.
// Drives add, read, density and clear words across several register profiles and checks
// every result word against a fixed expected word or a built-in model of the bucket store.
`timescale 1ns / 1ps
`default_nettype none
module multi_layer_coverage_histogram_tb;
   import mlch_pkg::*;

   localparam int N_LAYERS  = DEF_MAX_LAYERS;
   localparam int N_BUCKETS = DEF_MAX_BUCKETS;
   localparam int N_PIXELS  = DEF_MAX_PIXELS;
   localparam int N_PHASES  = 6;
   localparam int N_RANDOM  = 1600;
   localparam int N_DIRECT  = 13;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type e;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = CSR_BASE;
   logic [CSR_W-1:0] csr_wdata = '0;

   multi_layer_coverage_histogram i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // histogram state
   logic [31:0] bucket_mem [N_LAYERS][N_BUCKETS];
   logic [12:0] layer_size [N_LAYERS];
   logic [12:0] cfg_base   = 13'(RESET_BASE);
   logic [12:0] cfg_mult   = 13'(RESET_MULT);
   logic [4:0]  cfg_layers = 5'(RESET_LAYERS);
   logic [12:0] cfg_pixels = 13'(RESET_PIXELS);

   rsp_type pending_rsp [$];
   int      mismatches = 0;
   int      received   = 0;
   int      hold_cycles = 0;
   int      idle_mode   = 0;
   int      n_add = 0, n_read = 0, n_dens = 0, n_clear = 0, n_reject = 0;

   function automatic void zero_buckets();
      foreach (bucket_mem[l, b]) bucket_mem[l][b] = '0;
   endfunction

   function automatic void rebuild_sizes();
      longint unsigned c, m;
      c = (cfg_base == 0) ? 1 : cfg_base;
      m = (cfg_mult == 0) ? 1 : cfg_mult;
      if (c > N_BUCKETS) c = N_BUCKETS;
      for (int i = 0; i < N_LAYERS; i++) begin
         layer_size[i] = 13'(c);
         c = c * m;
         if (c > N_BUCKETS) c = N_BUCKETS;
      end
      zero_buckets();
   endfunction

   function automatic int active_layers();
      return (cfg_layers > N_LAYERS) ? N_LAYERS : int'(cfg_layers);
   endfunction

   function automatic int eff_width();
      return (cfg_pixels > N_PIXELS) ? N_PIXELS : int'(cfg_pixels);
   endfunction

   function automatic rsp_type histogram_step(req_type r);
      rsp_type o;
      longint unsigned cap, w, first, last, occ, tot;
      o = '0;
      occ = 0;
      tot = 0;
      if (r.command == CMD_CLEAR) begin
         zero_buckets();
         o.accepted = 1'b1;
         n_clear++;
         return o;
      end
      if (r.layer >= active_layers()) begin
         n_reject++;
         return o;
      end
      cap = layer_size[r.layer];
      o.accepted = 1'b1;
      case (r.command)
         CMD_ADD: begin
            n_add++;
            bucket_mem[r.layer][r.value % cap] += r.amount;
         end
         CMD_READ: begin
            n_read++;
            if (r.value < cap) o.bucket_count = bucket_mem[r.layer][r.value];
         end
         default: begin
            n_dens++;
            w = eff_width();
            if (w != 0) begin
               if (cap <= w) begin
                  first = (r.pixel_x * cap) / w;
                  if (first >= cap) first = cap - 1;
                  tot = 1;
                  occ = (bucket_mem[r.layer][first] != 0) ? 1 : 0;
               end else begin
                  first = (r.pixel_x * cap) / w;
                  last = ((r.pixel_x + 1) * cap) / w;
                  if (last <= first) last = first + 1;
                  if (last > cap) last = cap;
                  for (longint unsigned b = first; b < last; b++) begin
                     tot++;
                     if (bucket_mem[r.layer][b] != 0) occ++;
                  end
               end
               o.occupied_count = 13'(occ);
               o.column_buckets = 13'(tot);
               o.density_q16    = (tot != 0) ? 17'((occ << 16) / tot) : '0;
            end
         end
      endcase
      return o;
   endfunction

   function automatic req_type mk_req(cmd_type c, logic [3:0] l, logic [63:0] v,
                                      logic [31:0] a, logic [11:0] px);
      req_type r;
      r.command = c;
      r.layer   = l;
      r.value   = v;
      r.amount  = a;
      r.pixel_x = px;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int unsigned sel, nl, cap, w;
      r = '0;
      sel = $urandom_range(0, 999);
      nl = active_layers();
      w = eff_width();
      if (sel == 0) r.command = CMD_CLEAR;
      else if (sel < 450) r.command = CMD_ADD;
      else if (sel < 750) r.command = CMD_READ;
      else r.command = CMD_DENSITY;
      if (nl > 0 && $urandom_range(0, 9) != 0) r.layer = 4'($urandom_range(0, nl - 1));
      else r.layer = 4'($urandom);
      cap = layer_size[r.layer];
      r.value = {$urandom, $urandom};
      if (r.command == CMD_ADD && $urandom_range(0, 9) < 7)
         r.value = 64'($urandom_range(0, 2 * cap - 1));
      if (r.command == CMD_READ && $urandom_range(0, 9) < 8)
         r.value = 64'($urandom_range(0, cap - 1));
      case ($urandom_range(0, 9))
         0, 1:    r.amount = '0;
         2, 3, 4: r.amount = $urandom;
         default: r.amount = 32'($urandom_range(1, 4));
      endcase
      r.pixel_x = 12'($urandom);
      if (w > 0 && $urandom_range(0, 99) < 85) r.pixel_x = 12'($urandom_range(0, w - 1));
      return r;
   endfunction

   function automatic bit sender_idles();
      case (idle_mode)
         0:       return $urandom_range(0, 99) < 37;
         1:       return $urandom_range(0, 99) < 86;
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_word(req_type r, bit known, rsp_type e);
      rsp_type p;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      p = histogram_step(r);
      pending_rsp.push_back(known ? e : p);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [CSR_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_BASE:   begin cfg_base = d; rebuild_sizes(); end
         CSR_MULT:   begin cfg_mult = d; rebuild_sizes(); end
         CSR_LAYERS: begin cfg_layers = d[4:0]; rebuild_sizes(); end
         default:    cfg_pixels = d;
      endcase
      @(posedge clock);
   endtask

   // receive and compare
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         received++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.accepted !== e.accepted || rsp_data.bucket_count !== e.bucket_count
                || rsp_data.occupied_count !== e.occupied_count
                || rsp_data.column_buckets !== e.column_buckets
                || rsp_data.density_q16 !== e.density_q16) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch on word %0d: expected %p, got %p", received, e, rsp_data);
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (idle_mode)
            0:       rsp_stall <= $urandom_range(0, 99) < 86;
            1:       rsp_stall <= $urandom_range(0, 99) < 37;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   initial begin
      #300_000_000;
      $display("timeout with %0d words outstanding", pending_rsp.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      dir_row_type dir_rows [N_DIRECT];
      logic [12:0] ph_base   [N_PHASES] = '{13'd8, 13'd4096, 13'd0, 13'd5, 13'd2, 13'd2};
      logic [12:0] ph_mult   [N_PHASES] = '{13'd2, 13'd4096, 13'd3, 13'd0, 13'd4096, 13'd4096};
      logic [12:0] ph_layers [N_PHASES] = '{13'd16, 13'd31, 13'd5, 13'd1, 13'd3, 13'd3};
      logic [12:0] ph_pixels [N_PHASES] = '{13'd1024, 13'd4096, 13'd7, 13'd8191, 13'd0, 13'd1};
      int          ph_items  [N_PHASES] = '{350, 350, 350, 300, 200, 50};
      int          sent;

      dir_rows[0]  = '{mk_req(CMD_READ, 0, 0, 0, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[1]  = '{mk_req(CMD_ADD, 0, '1, '1, '1), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[2]  = '{mk_req(CMD_ADD, 0, 7, 1, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[3]  = '{mk_req(CMD_READ, 0, 7, 0, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[4]  = '{mk_req(CMD_ADD, 15, 0, 5, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[5]  = '{mk_req(CMD_READ, 15, 0, 0, 0), 1, rsp_type'{1'b1, 32'd5, 0, 0, 0}};
      dir_rows[6]  = '{mk_req(CMD_READ, 15, 4096, 0, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[7]  = '{mk_req(CMD_READ, 0, '1, 0, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};
      dir_rows[8]  = '{mk_req(CMD_DENSITY, 15, 0, 0, 0), 0, '0};
      dir_rows[9]  = '{mk_req(CMD_DENSITY, 0, 0, 0, '1), 0, '0};
      dir_rows[10] = '{mk_req(CMD_ADD, 0, 3, 9, 0), 0, '0};
      dir_rows[11] = '{mk_req(CMD_DENSITY, 0, 0, 0, 12'd384), 0, '0};
      dir_rows[12] = '{mk_req(CMD_CLEAR, 4'hf, '1, '1, '1), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0}};

      rebuild_sizes();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      idle_mode = 2;
      foreach (dir_rows[i]) send_word(dir_rows[i].r, dir_rows[i].known, dir_rows[i].e);
      send_word(mk_req(CMD_READ, 15, 0, 0, 0), 1, rsp_type'{1'b1, 32'd0, 0, 0, 0});

      sent = 0;
      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         repeat (8) @(posedge clock);
         if (ph_base[p] != cfg_base) write_csr(CSR_BASE, ph_base[p]);
         if (ph_mult[p] != cfg_mult) write_csr(CSR_MULT, ph_mult[p]);
         if (ph_layers[p][4:0] != cfg_layers) write_csr(CSR_LAYERS, ph_layers[p]);
         if (ph_pixels[p] != cfg_pixels) write_csr(CSR_PIXELS, ph_pixels[p]);
         for (int k = 0; k < ph_items[p]; k++) begin
            idle_mode = sent * 3 / N_RANDOM;
            if (p == 1 && k == 20) hold_cycles = 2000;
            if (k == ph_items[p] / 2) drain();
            send_word(random_req(), 0, '0);
            sent++;
         end
      end
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d adds, %0d reads, %0d density queries, %0d clears, %0d bad layers",
               n_add, n_read, n_dens, n_clear, n_reject);
      $display("over %0d register profiles; %0d result words checked", N_PHASES, received);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
